// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int EFF_W   = (OPERAND_WIDTH > 31) ? 31 : OPERAND_WIDTH;
  localparam int PROD_W  = 2 * EFF_W;
  localparam int DIV_W   = 2 * EFF_W + 1;
  localparam int RES_W   = 33;
  localparam int FUNC_W  = 3;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_EQ  = 3'd4,
    FN_LT  = 3'd5
  } func_e;

  typedef enum logic [3:0] {
    BS_IDLE, BS_MUL, BS_POST, BS_GCD, BS_GWAIT, BS_QUO, BS_QWAIT, BS_FIN, BS_DONE
  } back_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]        op;
    logic signed [EFF_W-1:0]  an;
    logic signed [EFF_W-1:0]  ad;
    logic signed [EFF_W-1:0]  bn;
    logic signed [EFF_W-1:0]  bd;
    logic                     bad_op;
    logic                     zden;
    logic                     pos;
  } item_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic signed [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quo;
    logic signed [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== design/rau_front.sv =====
// ----------------------------------------------------------------------------
// rau_front
// Input stage: accepts a transaction, registers signed operands and classifies them.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-1:0] a_den_i,
  input  logic [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-1:0] b_den_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output item_t                    item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !q_full_i;
  assign item_o     = item_q;

  always_comb begin
    item_d        = item_q;
    item_d.op     = func_i;
    item_d.an     = $signed(a_num_i[EFF_W-1:0]);
    item_d.ad     = $signed(a_den_i[EFF_W-1:0]);
    item_d.bn     = $signed(b_num_i[EFF_W-1:0]);
    item_d.bd     = $signed(b_den_i[EFF_W-1:0]);
    item_d.bad_op = (func_i > FN_LT);
    item_d.zden   = (a_den_i[EFF_W-1:0] == '0) || (b_den_i[EFF_W-1:0] == '0);
    item_d.pos    = ($signed(a_den_i[EFF_W-1:0]) > 0) == ($signed(b_den_i[EFF_W-1:0]) > 0);
    valid_d       = accept ? 1'b1 : (push_o ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== design/rau_queue.sv =====
// ----------------------------------------------------------------------------
// rau_queue
// Short FIFO between the input stage and the execution sequencer.
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== design/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Bit-serial signed divider, quotient and remainder truncate toward zero.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  quo_q, dv_q;
  logic              qneg_q, rneg_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  mag_n, mag_d;

  assign mag_n = req_i.dividend[DIV_W-1] ? DIV_W'(-req_i.dividend) : DIV_W'(req_i.dividend);
  assign mag_d = req_i.divisor[DIV_W-1]  ? DIV_W'(-req_i.divisor)  : DIV_W'(req_i.divisor);
  assign trial = {rem_q, quo_q[DIV_W-1]};

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = qneg_q ? -$signed(quo_q) : $signed(quo_q);
  assign rsp_o.rem  = rneg_q ? -$signed(rem_q) : $signed(rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring step: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= mag_n;
      dv_q   <= mag_d;
      qneg_q <= req_i.dividend[DIV_W-1] ^ req_i.divisor[DIV_W-1];
      rneg_q <= req_i.dividend[DIV_W-1];
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        rem_q <= DIV_W'(trial - {1'b0, dv_q});
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DIV_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/rau_back.sv =====
// ----------------------------------------------------------------------------
// rau_back
// Execution sequencer: multiplies, runs Euclid on the divider, forms results.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  item_t                   q_item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [RES_W-1:0] res_num_o,
  output logic signed [RES_W-1:0] res_den_o,
  output logic                    truth_o,
  output logic                    status_o
);

  back_state_e state_q, state_d;
  item_t       it_q;
  logic [1:0]  cnt_q, qidx_q;
  logic        gsel_q;
  logic signed [PROD_W-1:0] p_q [3];
  logic signed [DIV_W-1:0]  x_q, y_q, s_q, d_q, rnum_q, rden_q;
  logic signed [DIV_W-1:0]  g_q [2];
  logic signed [DIV_W-1:0]  qv_q [4];
  logic        truth_q, status_q;
  logic        out_valid_q;
  logic signed [RES_W-1:0]  out_num_q, out_den_q;
  logic        out_truth_q, out_status_q;

  logic signed [EFF_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [DIV_W-1:0]  sum;
  logic        is_addsub, is_eq, mul_last, gzero, q_last, out_load;
  div_req_t    dreq;
  div_rsp_t    drsp;

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign is_addsub = (it_q.op == FN_ADD) || (it_q.op == FN_SUB);
  assign is_eq     = (it_q.op == FN_EQ);
  assign mul_last  = is_addsub ? (cnt_q == 2'd2) : (cnt_q == 2'd1);
  assign gzero     = is_addsub ? (g_q[0] == '0) : ((g_q[0] == '0) || (g_q[1] == '0));
  assign q_last    = is_addsub ? (qidx_q == 2'd1) : (qidx_q == 2'd3);
  assign prod      = ma * mb;
  assign sum       = (it_q.op == FN_ADD) ? DIV_W'(p_q[0]) + DIV_W'(p_q[1])
                                         : DIV_W'(p_q[0]) - DIV_W'(p_q[1]);
  assign out_load  = (state_q == BS_DONE) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.bad_op) state_d = BS_DONE;
          else if (q_item_i.op == FN_EQ) state_d = BS_GCD;
          else state_d = BS_MUL;
        end
      end
      BS_MUL:   if (mul_last) state_d = BS_POST;
      BS_POST:  state_d = is_addsub ? BS_GCD : BS_DONE;
      BS_GCD: begin
        if (y_q != '0) state_d = BS_GWAIT;
        else if (!(is_eq && !gsel_q)) state_d = BS_QUO;
      end
      BS_GWAIT: if (drsp.done) state_d = BS_GCD;
      BS_QUO:   state_d = gzero ? BS_DONE : BS_QWAIT;
      BS_QWAIT: if (drsp.done) state_d = q_last ? BS_FIN : BS_QUO;
      BS_FIN:   state_d = BS_DONE;
      BS_DONE:  if (out_load) state_d = BS_IDLE;
      default:  state_d = BS_IDLE;
    endcase
  end

  // control outputs: multiplier operands, divider request, queue pop
  always_comb begin
    pop_o         = (state_q == BS_IDLE) && q_valid_i;
    ma            = it_q.an;
    mb            = it_q.bd;
    dreq.start    = 1'b0;
    dreq.dividend = x_q;
    dreq.divisor  = y_q;
    case (it_q.op)
      FN_ADD, FN_SUB, FN_LT: begin
        case (cnt_q)
          2'd0:    begin ma = it_q.an; mb = it_q.bd; end
          2'd1:    begin ma = it_q.bn; mb = it_q.ad; end
          default: begin ma = it_q.ad; mb = it_q.bd; end
        endcase
      end
      FN_MUL: begin
        if (cnt_q == 2'd0) begin ma = it_q.an; mb = it_q.bn; end
        else begin ma = it_q.ad; mb = it_q.bd; end
      end
      FN_DIV: begin
        if (cnt_q == 2'd0) begin ma = it_q.an; mb = it_q.bd; end
        else begin ma = it_q.ad; mb = it_q.bn; end
      end
      default: ;
    endcase
    case (state_q)
      BS_GCD: dreq.start = (y_q != '0);
      BS_QUO: begin
        dreq.start = !gzero;
        if (is_addsub) begin
          dreq.dividend = (qidx_q == 2'd0) ? s_q : d_q;
          dreq.divisor  = g_q[0];
        end else begin
          case (qidx_q)
            2'd0:    dreq.dividend = DIV_W'(it_q.an);
            2'd1:    dreq.dividend = DIV_W'(it_q.ad);
            2'd2:    dreq.dividend = DIV_W'(it_q.bn);
            default: dreq.dividend = DIV_W'(it_q.bd);
          endcase
          dreq.divisor = qidx_q[1] ? g_q[1] : g_q[0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BS_IDLE: begin
        if (q_valid_i) begin
          it_q     <= q_item_i;
          cnt_q    <= '0;
          qidx_q   <= '0;
          gsel_q   <= 1'b0;
          rnum_q   <= '0;
          rden_q   <= '0;
          truth_q  <= 1'b0;
          status_q <= q_item_i.bad_op;
          x_q      <= DIV_W'(q_item_i.an);
          y_q      <= DIV_W'(q_item_i.ad);
        end
      end
      BS_MUL: begin
        p_q[cnt_q] <= prod;
        cnt_q      <= cnt_q + 1'b1;
      end
      BS_POST: begin
        case (it_q.op)
          FN_ADD, FN_SUB: begin
            s_q <= sum;
            d_q <= DIV_W'(p_q[2]);
            x_q <= sum;
            y_q <= DIV_W'(p_q[2]);
          end
          FN_MUL, FN_DIV: begin
            rnum_q <= DIV_W'(p_q[0]);
            rden_q <= DIV_W'(p_q[1]);
          end
          default: begin
            status_q <= it_q.zden;
            truth_q  <= !it_q.zden && (it_q.pos ? (p_q[0] < p_q[1]) : (p_q[0] > p_q[1]));
          end
        endcase
      end
      BS_GCD: begin
        if (y_q == '0) begin
          g_q[gsel_q] <= x_q;
          if (is_eq && !gsel_q) begin
            gsel_q <= 1'b1;
            x_q    <= DIV_W'(it_q.bn);
            y_q    <= DIV_W'(it_q.bd);
          end
        end
      end
      BS_GWAIT: begin
        if (drsp.done) begin
          x_q <= y_q;
          y_q <= drsp.rem;
        end
      end
      BS_QUO: if (gzero) status_q <= 1'b1;
      BS_QWAIT: begin
        if (drsp.done) begin
          qv_q[qidx_q] <= drsp.quo;
          qidx_q       <= qidx_q + 1'b1;
        end
      end
      BS_FIN: begin
        if (is_addsub) begin
          rnum_q <= qv_q[0];
          rden_q <= qv_q[1];
        end else begin
          truth_q <= (qv_q[0] == qv_q[2]) && (qv_q[1] == qv_q[3]);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_num_q    <= RES_W'(rnum_q);
      out_den_q    <= RES_W'(rden_q);
      out_truth_q  <= truth_q;
      out_status_q <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = out_num_q;
  assign res_den_o   = out_den_q;
  assign truth_o     = out_truth_q;
  assign status_o    = out_status_q;

endmodule

// ===== design/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit. Each transaction carries two signed fractions and
// an operation code and yields one result. Multiply, divide and less-than form
// their products, one 16x16 product per cycle. Add, subtract and equal
// run Euclid's algorithm on a bit-serial divider, one division per remainder
// step, plus two or four final quotients.
// A two-entry queue lets new transactions enter while one is executing, and
// a result register holds a finished result until it is taken.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Top level: input stage, queue and execution sequencer.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core import rau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-1:0] a_den_i,
  input  logic [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-1:0] b_den_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [RES_W-1:0]  res_num_o,
  output logic signed [RES_W-1:0]  res_den_o,
  output logic                     truth_o,
  output logic                     status_o
);

  logic  push, pop, q_full, q_valid;
  item_t f_item, q_item;

  rau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (f_item)
  );

  rau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  rau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .truth_o     (truth_o),
    .status_o    (status_o)
  );

endmodule

// ===== design/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_assertions
// Port-level assertions for the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_assertions import rau_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [FUNC_W-1:0]        func_i,
  input logic [OPERAND_WIDTH-1:0] a_num_i,
  input logic [OPERAND_WIDTH-1:0] a_den_i,
  input logic [OPERAND_WIDTH-1:0] b_num_i,
  input logic [OPERAND_WIDTH-1:0] b_den_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [RES_W-1:0]         res_num_o,
  input logic [RES_W-1:0]         res_den_o,
  input logic                     truth_o,
  input logic                     status_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_num_o) && $stable(res_den_o))
    else $error("stalled result changed");

  // an error result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> res_num_o == '0 && res_den_o == '0 && !truth_o)
    else $error("error result with nonzero fields");

  // a true compare carries no fraction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truth_o |-> res_num_o == '0 && res_den_o == '0)
    else $error("compare result with fraction");

endmodule

bind rational_arithmetic_unit_core rau_assertions u_rau_assertions (.*);
